>>> hw/rtl/binary_galois_field_alu_core_defines.svh
// Assertion macros shared by the GF(2^m) ALU core.
`ifndef BINARY_GALOIS_FIELD_ALU_CORE_DEFINES_SVH
`define BINARY_GALOIS_FIELD_ALU_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GFALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GFALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gfalu_pkg.sv
// Shared constants, operation codes and state type for the GF(2^m) ALU.
`timescale 1ns / 1ps
package gfalu_pkg;

    localparam int MAX_DEGREE_DEF = 16;
    localparam int OPERAND_W      = 16;
    localparam int EXP_W          = 32;
    localparam int OP_W           = 2;
    localparam int GEN_W          = 17;
    localparam int RES_W          = 16;
    localparam int TDATA_IN_W     = 2 * OPERAND_W + EXP_W;

    localparam logic [GEN_W-1:0] GEN_RESET = 17'd283;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_MUL = 2'd1;
    localparam logic [OP_W-1:0] OP_POW = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARED,
        S_BMUL,
        S_ERED,
        S_ECHK,
        S_SQR,
        S_PMUL,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/gfalu_mul_serial.sv
// Bit-serial GF(2^m) multiplier: Horner scheme, multiplier bits MSB first.
`timescale 1ns / 1ps
module gfalu_mul_serial #(
    parameter int MAX_DEGREE = gfalu_pkg::MAX_DEGREE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [MAX_DEGREE-1:0] i_x,
    input  logic [((MAX_DEGREE > gfalu_pkg::OPERAND_W) ? MAX_DEGREE
                   : gfalu_pkg::OPERAND_W)-1:0] i_y,
    input  logic [MAX_DEGREE:0]   i_gen,
    input  logic [MAX_DEGREE:0]   i_deg_mask,
    output logic                  o_done,
    output logic [MAX_DEGREE-1:0] o_product
);

    localparam int GW = MAX_DEGREE + 1;
    localparam int YW = (MAX_DEGREE > gfalu_pkg::OPERAND_W) ? MAX_DEGREE
                                                            : gfalu_pkg::OPERAND_W;
    localparam int CW = $clog2(YW + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [MAX_DEGREE-1:0] r_x;
    logic [YW-1:0]         r_y;
    logic [MAX_DEGREE-1:0] r_acc;
    logic [MAX_DEGREE-1:0] n_acc;

    // acc = acc shifted up one place and reduced mod g, then add x when the current multiplier bit is set
    always_comb begin
        logic [GW-1:0] step;
        step = {r_acc, 1'b0};
        if (|(step & i_deg_mask)) begin
            step = step ^ i_gen;
        end
        if (r_y[YW-1]) begin
            step = step ^ GW'(r_x);
        end
        n_acc = step[MAX_DEGREE-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == CW'(1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
            r_cnt <= CW'(YW);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[YW-2:0], 1'b0};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

>>> hw/rtl/binary_galois_field_alu_core.sv
// Top level of the GF(2^m) ALU: add, multiply and power over a programmable field.
`timescale 1ns / 1ps
// One item at a time. The field is set by i_cfg_wr_data, whose highest set bit gives
// the degree m; write it only while the block is idle. Add, the unused code, a zero
// power base and a field of degree below one go straight to the result. Multiply and
// power share one bit-serial field multiplier that steps through the W bits of its
// multiplier, W being the larger of 16 and MAX_DEGREE. Multiply costs two products
// (operand reduction, then the product). Power reduces the base with one product,
// folds the exponent modulo 2^m-1 one bit per cycle, tests the folded value, then
// takes MAX_DEGREE squarings plus one product per set bit of the folded exponent,
// which has at most MAX_DEGREE-1 of them. A folded exponent of 0 or 1 ends after the
// test. A stalled sink can hold the block in its done state. A finished result waits
// in the output register while the next item is taken.
module binary_galois_field_alu_core #(
    parameter int MAX_DEGREE = gfalu_pkg::MAX_DEGREE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [gfalu_pkg::GEN_W-1:0]           i_cfg_wr_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [15:0] operand_a, [31:16] operand_b, [63:32] exponent
    input  logic [gfalu_pkg::TDATA_IN_W-1:0]      i_s_tdata,
    // [1:0] operation
    input  logic [gfalu_pkg::OP_W-1:0]            i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [15:0] result
    output logic [gfalu_pkg::RES_W-1:0]           o_m_tdata
);

    `include "binary_galois_field_alu_core_defines.svh"

    localparam int MD = MAX_DEGREE;
    localparam int GW = MAX_DEGREE + 1;
    localparam int YW = (MAX_DEGREE > gfalu_pkg::OPERAND_W) ? MAX_DEGREE
                                                            : gfalu_pkg::OPERAND_W;
    localparam int OW = gfalu_pkg::OPERAND_W;
    localparam int EW = gfalu_pkg::EXP_W;
    localparam int RW = gfalu_pkg::RES_W;
    localparam int ECNT_W = $clog2(EW + 1);
    localparam int BCNT_W = $clog2(MD + 1);

    gfalu_pkg::t_state r_state;
    gfalu_pkg::t_state n_state;
    logic              r_go;
    logic              n_go;

    logic [GW-1:0]     r_gen;
    logic [GW-1:0]     r_deg_mask;
    logic [MD-1:0]     r_order;
    logic [GW-1:0]     cfg_src;
    logic [GW-1:0]     cfg_mask;
    logic              deg_ok;

    logic [gfalu_pkg::OP_W-1:0] r_op;
    logic [OW-1:0]     r_a;
    logic [OW-1:0]     r_b;
    logic [EW-1:0]     r_e;
    logic [MD-1:0]     r_ered;
    logic [MD-1:0]     n_ered;
    logic [ECNT_W-1:0] r_ecnt;
    logic [MD-1:0]     r_ared;
    logic [MD-1:0]     r_acc;
    logic [BCNT_W-1:0] r_bitcnt;
    logic [RW-1:0]     r_res;

    logic              r_m_valid;
    logic [RW-1:0]     r_m_data;

    logic              s_fire;
    logic              out_free;
    logic              bit_adv;
    logic              last_bit;
    logic [OW-1:0]     in_a;
    logic              in_mul_phase;
    logic              fold_last;

    logic              mul_start;
    logic [MD-1:0]     mul_x;
    logic [YW-1:0]     mul_y;
    logic              mul_done;
    logic [MD-1:0]     mul_product;

    // Field register: reset and writes share the degree detection
    assign cfg_src = i_rst_n ? GW'(i_cfg_wr_data) : GW'(gfalu_pkg::GEN_RESET);

    always_comb begin
        cfg_mask = '0;
        for (int i = 0; i < GW; i++) begin
            if (cfg_src[i]) begin
                cfg_mask = GW'(1) << i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_gen      <= cfg_src;
            r_deg_mask <= cfg_mask;
            r_order    <= MD'(cfg_mask - GW'(1));
        end
    end

    assign deg_ok   = |r_deg_mask[GW-1:1];
    assign in_a     = i_s_tdata[OW-1:0];
    assign s_fire   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;
    assign last_bit = (r_bitcnt == BCNT_W'(1));
    assign bit_adv  = mul_done && ((r_state == gfalu_pkg::S_PMUL)
                      || (r_state == gfalu_pkg::S_SQR && !r_ered[MD-1]));
    assign in_mul_phase = (r_state == gfalu_pkg::S_ARED) || (r_state == gfalu_pkg::S_BMUL)
                          || (r_state == gfalu_pkg::S_SQR) || (r_state == gfalu_pkg::S_PMUL);
    assign fold_last    = (r_state == gfalu_pkg::S_ERED) && (r_ecnt == ECNT_W'(1));

    // Exponent fold: r = 2r + bit, minus the order when it reaches it
    always_comb begin
        logic [GW-1:0] t;
        t = {r_ered, r_e[EW-1]};
        if (t >= GW'(r_order)) begin
            t = t - GW'(r_order);
        end
        n_ered = t[MD-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        unique case (r_state)
            gfalu_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (deg_ok && (i_s_tuser == gfalu_pkg::OP_MUL
                        || (i_s_tuser == gfalu_pkg::OP_POW && in_a != '0))) begin
                        n_state = gfalu_pkg::S_ARED;
                        n_go    = 1'b1;
                    end else begin
                        n_state = gfalu_pkg::S_DONE;
                    end
                end
            end
            gfalu_pkg::S_ARED: begin
                if (mul_done) begin
                    if (r_op == gfalu_pkg::OP_MUL) begin
                        n_state = gfalu_pkg::S_BMUL;
                        n_go    = 1'b1;
                    end else begin
                        n_state = gfalu_pkg::S_ERED;
                    end
                end
            end
            gfalu_pkg::S_BMUL: begin
                if (mul_done) begin
                    n_state = gfalu_pkg::S_DONE;
                end
            end
            gfalu_pkg::S_ERED: begin
                if (r_ecnt == ECNT_W'(1)) begin
                    n_state = gfalu_pkg::S_ECHK;
                end
            end
            gfalu_pkg::S_ECHK: begin
                if (r_ered == '0 || r_ered == MD'(1)) begin
                    n_state = gfalu_pkg::S_DONE;
                end else begin
                    n_state = gfalu_pkg::S_SQR;
                    n_go    = 1'b1;
                end
            end
            gfalu_pkg::S_SQR, gfalu_pkg::S_PMUL: begin
                if (mul_done) begin
                    if (!bit_adv) begin
                        n_state = gfalu_pkg::S_PMUL;
                        n_go    = 1'b1;
                    end else if (last_bit) begin
                        n_state = gfalu_pkg::S_DONE;
                    end else begin
                        n_state = gfalu_pkg::S_SQR;
                        n_go    = 1'b1;
                    end
                end
            end
            gfalu_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = gfalu_pkg::S_IDLE;
                end
            end
            default: n_state = gfalu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfalu_pkg::S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    // Outputs of the sequencer: multiplier operands per phase
    always_comb begin
        mul_start  = r_go;
        o_s_tready = (r_state == gfalu_pkg::S_IDLE);
        unique case (r_state)
            gfalu_pkg::S_ARED: begin
                mul_x = MD'(1);
                mul_y = YW'(r_a);
            end
            gfalu_pkg::S_BMUL: begin
                mul_x = r_ared;
                mul_y = YW'(r_b);
            end
            gfalu_pkg::S_PMUL: begin
                mul_x = r_acc;
                mul_y = YW'(r_ared);
            end
            default: begin
                mul_x = r_acc;
                mul_y = YW'(r_acc);
            end
        endcase
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_op  <= i_s_tuser;
            r_a   <= in_a;
            r_b   <= i_s_tdata[2*OW-1:OW];
            r_e   <= i_s_tdata[2*OW+EW-1:2*OW];
            r_res <= (i_s_tuser == gfalu_pkg::OP_ADD)
                     ? RW'(in_a ^ i_s_tdata[2*OW-1:OW]) : '0;
        end
        case (r_state)
            gfalu_pkg::S_ARED: begin
                if (mul_done) begin
                    r_ared <= mul_product;
                    r_ered <= '0;
                    r_ecnt <= ECNT_W'(EW);
                end
            end
            gfalu_pkg::S_BMUL: begin
                if (mul_done) begin
                    r_res <= RW'(mul_product);
                end
            end
            gfalu_pkg::S_ERED: begin
                r_ered <= n_ered;
                r_e    <= {r_e[EW-2:0], 1'b0};
                r_ecnt <= r_ecnt - ECNT_W'(1);
            end
            gfalu_pkg::S_ECHK: begin
                r_acc    <= MD'(1);
                r_bitcnt <= BCNT_W'(MD);
                r_res    <= (r_ered == '0) ? RW'(1) : RW'(r_a);
            end
            gfalu_pkg::S_SQR, gfalu_pkg::S_PMUL: begin
                if (mul_done) begin
                    r_acc <= mul_product;
                end
                if (bit_adv) begin
                    r_ered   <= {r_ered[MD-2:0], 1'b0};
                    r_bitcnt <= r_bitcnt - BCNT_W'(1);
                    r_res    <= RW'(mul_product);
                end
            end
            default: ;
        endcase
    end

    // Output register: hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == gfalu_pkg::S_DONE && out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gfalu_pkg::S_DONE && out_free) begin
            r_m_data <= r_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    gfalu_mul_serial #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mul_start),
        .i_x        (mul_x),
        .i_y        (mul_y),
        .i_gen      (r_gen),
        .i_deg_mask (r_deg_mask),
        .o_done     (mul_done),
        .o_product  (mul_product)
    );

    `GFALU_ASSERT_NOW(a_deg_mask_onehot, 1'b1, $onehot0(r_deg_mask), "degree mask not one-hot")
    `GFALU_ASSERT_NOW(a_done_in_mul_phase, mul_done, in_mul_phase, "done outside a product phase")
    `GFALU_ASSERT_NOW(a_product_reduced, mul_done, (GW'(mul_product) < r_deg_mask), "product not reduced")
    `GFALU_ASSERT_NEXT(a_exp_folded, fold_last, (r_ered < r_order), "exponent fold out of range")

endmodule
